// ----- rtl/dks_pkg.sv -----
// DES key schedule package: shared types, permutation tables and helpers.
// No dependencies; used by every module of the key schedule.
package dks_pkg;

    localparam int HALF_W   = 28;
    localparam int KEY_W    = 64;
    localparam int SUBKEY_W = 48;
    localparam int ROUND_W  = 4;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 4'd15;

    // Rounds that rotate by two places; each round has its own bit, LSB first.
    localparam logic [15:0] ROT_TWO = 16'b0111_1110_1111_1100;

    localparam logic [6:0] PC1_TAB [56] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    localparam logic [5:0] PC2_TAB [48] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    typedef struct packed {
        logic [HALF_W-1:0] c;
        logic [HALF_W-1:0] d;
    } t_halves;

    typedef struct packed {
        logic [ROUND_W-1:0]  round_index;
        logic [SUBKEY_W-1:0] subkey;
        logic                last;
    } t_result;

    // Key permutation: key bits count from the MSB; parity bits drop out.
    function automatic t_halves pc1(input logic [KEY_W-1:0] key);
        logic [2*HALF_W-1:0] r;
        int i;
        r = '0;
        for (i = 0; i < 2*HALF_W; i++) begin
            r[2*HALF_W-1-i] = key[KEY_W - int'(PC1_TAB[i])];
        end
        return t_halves'(r);
    endfunction

    // Subkey compression over C:D.
    function automatic logic [SUBKEY_W-1:0] pc2(input t_halves h);
        logic [2*HALF_W-1:0] j;
        logic [SUBKEY_W-1:0] r;
        int i;
        j = h;
        r = '0;
        for (i = 0; i < SUBKEY_W; i++) begin
            r[SUBKEY_W-1-i] = j[2*HALF_W - int'(PC2_TAB[i])];
        end
        return r;
    endfunction

    // 28-bit left rotation by one or two places.
    function automatic logic [HALF_W-1:0] rot(input logic [HALF_W-1:0] v, input logic two);
        logic [HALF_W-1:0] r;
        if (two) begin
            r = {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]};
        end else begin
            r = {v[HALF_W-2:0], v[HALF_W-1]};
        end
        return r;
    endfunction

endpackage

// ----- rtl/dks_front.sv -----
// Key schedule front end: takes keys, applies the initial key permutation and
// holds the C/D halves in a two-entry queue for the round engine. Uses dks_pkg.
module dks_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [dks_pkg::KEY_W-1:0] i_key,
    output logic                    o_valid,
    output dks_pkg::t_halves        o_halves,
    input  logic                    i_take
);

    dks_pkg::t_halves r_mem [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_count, n_count;
    logic             wr_en, rd_en;

    assign full     = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_halves = r_mem[r_rd_ptr];
    assign wr_en    = push && !full;
    assign rd_en    = i_take && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ wr_en;
        n_rd_ptr = r_rd_ptr ^ rd_en;
        n_count  = r_count + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= dks_pkg::pc1(i_key);
        end
    end

endmodule

// ----- rtl/dks_round.sv -----
// Key schedule round engine: rotates C/D once per cycle unless the result queue is
// full, and issues one compressed subkey per round. Uses dks_pkg.
module dks_round (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  dks_pkg::t_halves i_halves,
    output logic             o_take,
    input  logic             i_out_full,
    output logic             o_issue,
    output dks_pkg::t_result o_result
);

    dks_pkg::t_halves            r_h, n_h;
    logic [dks_pkg::ROUND_W-1:0] r_round, n_round;
    logic                        r_busy, n_busy;
    dks_pkg::t_halves            rotated;
    logic                        is_last;

    always_comb begin
        rotated.c = dks_pkg::rot(r_h.c, dks_pkg::ROT_TWO[r_round]);
        rotated.d = dks_pkg::rot(r_h.d, dks_pkg::ROT_TWO[r_round]);
        is_last   = (r_round == dks_pkg::LAST_ROUND);
        o_issue   = r_busy && !i_out_full;

        o_result.round_index = r_round;
        o_result.subkey      = dks_pkg::pc2(rotated);
        o_result.last        = is_last;

        n_h     = r_h;
        n_round = r_round;
        n_busy  = r_busy;
        o_take  = 1'b0;

        if (!r_busy || (o_issue && is_last)) begin
            // idle, or finishing a key: start the next one without a gap
            if (i_valid) begin
                o_take  = 1'b1;
                n_h     = i_halves;
                n_round = '0;
                n_busy  = 1'b1;
            end else begin
                n_busy  = 1'b0;
            end
        end else if (o_issue) begin
            n_h     = rotated;
            n_round = r_round + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
        end else begin
            r_busy  <= n_busy;
            r_round <= n_round;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
    end

endmodule

// ----- rtl/dks_outq.sv -----
// Key schedule result queue: two-entry buffer between the round engine and
// the consumer; the engine stalls only while both entries are full. Uses dks_pkg.
module dks_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_write,
    input  dks_pkg::t_result i_result,
    output logic             o_full,
    output logic             empty,
    input  logic             pop,
    output dks_pkg::t_result o_result
);

    dks_pkg::t_result r_mem [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_count;
    logic             wr_en, rd_en;

    assign o_full   = (r_count == 2'd2);
    assign empty    = (r_count == 2'd0);
    assign o_result = r_mem[r_rd_ptr];
    assign wr_en    = i_write && !o_full;
    assign rd_en    = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr ^ wr_en;
            r_rd_ptr <= r_rd_ptr ^ rd_en;
            r_count  <= r_count + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

endmodule

// ----- rtl/des_key_schedule.sv -----
// DES key schedule top level: one key request in, sixteen subkeys out.
// A taken key goes to the engine's C/D register; subkeys then enter the result queue
// one round a cycle unless it is full, and the next key loads as the last one issues.
// A two-entry key queue and a two-entry result queue decouple both sides.
// Reset (synchronous, active low) empties both queues and idles the engine.
// Depends on dks_pkg, dks_front, dks_round, dks_outq.
module des_key_schedule (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // key requests
    input  logic                        push,
    output logic                        full,
    input  logic [dks_pkg::KEY_W-1:0]   i_key,
    // subkey results
    output logic                        empty,
    input  logic                        pop,
    output logic [dks_pkg::ROUND_W-1:0] o_round_index,
    output logic [dks_pkg::SUBKEY_W-1:0] o_subkey,
    output logic                        o_last
);

    logic             key_valid;
    dks_pkg::t_halves key_halves;
    logic             key_take;
    logic             out_full;
    logic             issue;
    dks_pkg::t_result eng_result;
    dks_pkg::t_result head;

    // Front: key permutation on intake, queued halves wait for the engine.
    dks_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_key    (i_key),
        .o_valid  (key_valid),
        .o_halves (key_halves),
        .i_take   (key_take)
    );

    // Back: one rotation plus subkey compression per unstalled cycle; the next key is
    // loaded in the same cycle the final subkey issues, so keys run without a gap.
    dks_round u_round (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (key_valid),
        .i_halves   (key_halves),
        .o_take     (key_take),
        .i_out_full (out_full),
        .o_issue    (issue),
        .o_result   (eng_result)
    );

    // Result queue: the engine runs while the consumer holds results, until full.
    dks_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_write  (issue),
        .i_result (eng_result),
        .o_full   (out_full),
        .empty    (empty),
        .pop      (pop),
        .o_result (head)
    );

    assign o_round_index = head.round_index;
    assign o_subkey      = head.subkey;
    assign o_last        = head.last;

endmodule
